// ===== hw/rtl/dedup_bounded_task_queue_top_defines.svh =====
// Assertion macros for the deduplicating task queue.
// Used by the port checker; no other dependencies.
`ifndef DEDUP_BOUNDED_TASK_QUEUE_TOP_DEFINES_SVH
`define DEDUP_BOUNDED_TASK_QUEUE_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define DBTQ_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define DBTQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/dbtq_pkg.sv =====
// Types and constants shared by the deduplicating task queue modules.
// No dependencies.
package dbtq_pkg;

   localparam int KEY_FIELD_W = 64;
   localparam int QCOUNT_W    = 7;
   localparam int ACOUNT_W    = 4;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 7;

   localparam logic [CSR_INDEX_W-1:0] CSR_CAPACITY       = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEFAULT_POLICY = 4'd1;

   localparam logic [CSR_DATA_W-1:0] CAPACITY_RESET = 7'd64;

   typedef enum logic [2:0] {
      OP_ENQUEUE,
      OP_POP,
      OP_FINISH,
      OP_CLEAR,
      OP_STOP
   } op_type;

   typedef enum logic [1:0] {
      POL_DROP_NEWEST,
      POL_DROP_OLDEST,
      POL_ADMIT,
      POL_DEFAULT
   } policy_type;

   typedef enum logic [2:0] {
      STAT_DONE,
      STAT_DUPLICATE,
      STAT_FULL_REJECTED,
      STAT_STOPPED,
      STAT_EMPTY,
      STAT_ACTIVE_FULL
   } status_type;

   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_POPPED,
      KIND_EVICTED
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_QSCAN,
      ST_ASCAN,
      ST_APPEND,
      ST_POP,
      ST_FINISH,
      ST_RESP
   } state_type;

   typedef struct packed {
      op_type                 op;
      logic [KEY_FIELD_W-1:0] task_key;
      policy_type             policy;
   } req_type;

   typedef struct packed {
      status_type             status;
      kind_type               out_kind;
      logic [KEY_FIELD_W-1:0] out_key;
      logic [QCOUNT_W-1:0]    queue_count;
      logic [ACOUNT_W-1:0]    active_count;
      logic                   stopped_flag;
   } rsp_type;

   typedef struct packed {
      logic lookup;
      logic finish;
      logic insert;
   } act_cmd_type;

   typedef struct packed {
      logic done;
      logic hit;
      logic full;
   } act_stat_type;

endpackage

// ===== hw/rtl/dbtq_active_table.sv =====
// Active key table: key memory, valid bits, count and serial key search.
// Depends on dbtq_pkg.
module dbtq_active_table #(
   parameter int ACTIVE_DEPTH = 8,
   parameter int KEY_WIDTH    = 64,
   parameter int AW           = $clog2(ACTIVE_DEPTH + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  dbtq_pkg::act_cmd_type  cmd,
   input  logic [KEY_WIDTH-1:0]   key,
   output dbtq_pkg::act_stat_type stat,
   output logic [AW-1:0]          count
);
   import dbtq_pkg::*;

   localparam int IW = (ACTIVE_DEPTH > 1) ? $clog2(ACTIVE_DEPTH) : 1;

   logic [KEY_WIDTH-1:0]    act_mem [ACTIVE_DEPTH];
   logic [KEY_WIDTH-1:0]    rdata_ff;
   logic [ACTIVE_DEPTH-1:0] valid_ff, valid_in;
   logic [AW-1:0]           cnt_ff, cnt_in;
   logic [IW-1:0]           idx_ff, idx_in;
   logic [IW-1:0]           cmp_idx_ff, cmp_idx_in;
   logic                    scan_ff, scan_in;
   logic                    cmp_v_ff, cmp_v_in;
   logic                    cmp_last_ff, cmp_last_in;
   logic                    fin_ff, fin_in;
   logic                    hit_ff, hit_in;
   logic                    done_ff, done_in;
   logic [IW-1:0]           free_idx;
   logic                    key_hit;

   always_comb begin
      free_idx = '0;
      for (int i = ACTIVE_DEPTH - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_idx = IW'(i);
         end
      end
   end

   assign key_hit = cmp_v_ff && valid_ff[cmp_idx_ff] && (rdata_ff == key);

   always_comb begin
      valid_in    = valid_ff;
      cnt_in      = cnt_ff;
      idx_in      = idx_ff;
      scan_in     = scan_ff;
      fin_in      = fin_ff;
      hit_in      = hit_ff;
      cmp_v_in    = 1'b0;
      cmp_idx_in  = idx_ff;
      cmp_last_in = (idx_ff == IW'(ACTIVE_DEPTH - 1));
      done_in     = cmp_v_ff && cmp_last_ff;
      if (cmd.lookup || cmd.finish) begin
         scan_in = 1'b1;
         idx_in  = '0;
         hit_in  = 1'b0;
         fin_in  = cmd.finish;
      end
      if (scan_ff) begin
         cmp_v_in = 1'b1;
         idx_in   = idx_ff + IW'(1);
         if (cmp_last_in) begin
            scan_in = 1'b0;
         end
      end
      if (key_hit) begin
         hit_in = 1'b1;
         if (fin_ff) begin
            valid_in[cmp_idx_ff] = 1'b0;
            cnt_in               = cnt_ff - AW'(1);
         end
      end
      if (cmd.insert) begin
         valid_in[free_idx] = 1'b1;
         cnt_in             = cnt_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.insert) begin
         act_mem[free_idx] <= key;
      end
      rdata_ff <= act_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         cnt_ff   <= '0;
         scan_ff  <= 1'b0;
         cmp_v_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         cnt_ff   <= cnt_in;
         scan_ff  <= scan_in;
         cmp_v_ff <= cmp_v_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      cmp_idx_ff  <= cmp_idx_in;
      cmp_last_ff <= cmp_last_in;
      fin_ff      <= fin_in;
      hit_ff      <= hit_in;
   end

   assign stat.done = done_ff;
   assign stat.hit  = hit_ff;
   assign stat.full = &valid_ff;
   assign count     = cnt_ff;

endmodule

// ===== hw/rtl/dedup_bounded_task_queue_top.sv =====
// Deduplicating bounded task queue; one command at a time, one rsp_valid strobe per command.
// Enqueue runs a serial duplicate search: one queue memory read per pending key, then
// one active table read per table entry.
// busy stays high until the result strobe; results cannot be stalled.
// Synchronous reset empties the queue and active table and restores both registers.
module dedup_bounded_task_queue_top #(
   parameter int QUEUE_DEPTH  = 64,
   parameter int ACTIVE_DEPTH = 8,
   parameter int KEY_WIDTH    = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  dbtq_pkg::req_type                    req,
   output logic                                 rsp_valid,
   output dbtq_pkg::rsp_type                    rsp,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [dbtq_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [dbtq_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import dbtq_pkg::*;

   localparam int QW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int EW = (CW > CSR_DATA_W) ? CW : CSR_DATA_W;
   localparam int AW = $clog2(ACTIVE_DEPTH + 1);

   state_type               state_ff, state_in;
   req_type                 req_ff, req_in;
   logic [QW-1:0]           head_ff, head_in;
   logic [QW-1:0]           tail_ff, tail_in;
   logic [CW-1:0]           count_ff, count_in;
   logic                    stop_ff, stop_in;
   logic [CSR_DATA_W-1:0]   capacity_ff, capacity_in;
   policy_type              default_policy_ff, default_policy_in;
   logic [QW-1:0]           scan_ptr_ff, scan_ptr_in;
   logic [CW-1:0]           scan_rem_ff, scan_rem_in;
   logic                    q_cmp_v_ff, q_cmp_v_in;
   logic                    qhit_ff, qhit_in;
   logic                    evict_ff, evict_in;
   status_type              status_ff, status_in;
   kind_type                kind_ff, kind_in;
   logic [KEY_FIELD_W-1:0]  okey_ff, okey_in;

   logic [KEY_WIDTH-1:0]    q_mem [QUEUE_DEPTH];
   logic [KEY_WIDTH-1:0]    q_rdata_ff;
   logic [QW-1:0]           q_raddr;
   logic                    q_we;

   logic [KEY_WIDTH-1:0]    key_m;
   logic [KEY_WIDTH-1:0]    act_key;
   act_cmd_type             act_cmd;
   act_stat_type            act_stat;
   logic [AW-1:0]           act_count;
   policy_type              pol;
   logic [EW-1:0]           eff_cap;
   logic                    at_cap;
   logic                    at_depth;
   logic                    reject;
   logic                    scan_done;

   function automatic logic [QW-1:0] wrap_inc(input logic [QW-1:0] p);
      wrap_inc = (p == QW'(QUEUE_DEPTH - 1)) ? '0 : p + QW'(1);
   endfunction

   dbtq_active_table #(
      .ACTIVE_DEPTH (ACTIVE_DEPTH),
      .KEY_WIDTH    (KEY_WIDTH),
      .AW           (AW)
   ) u_active (
      .clock (clock),
      .reset (reset),
      .cmd   (act_cmd),
      .key   (act_key),
      .stat  (act_stat),
      .count (act_count)
   );

   assign key_m     = req_ff.task_key[KEY_WIDTH-1:0];
   assign scan_done = (scan_rem_ff == '0) && !q_cmp_v_ff;
   assign at_depth  = (count_ff == CW'(QUEUE_DEPTH));
   assign at_cap    = (EW'(count_ff) >= eff_cap);
   assign reject    = at_cap && ((pol == POL_DROP_NEWEST) || ((pol == POL_ADMIT) && at_depth));

   always_comb begin
      eff_cap = EW'(capacity_ff);
      if (eff_cap == '0) begin
         eff_cap = EW'(1);
      end
      if (eff_cap > EW'(QUEUE_DEPTH)) begin
         eff_cap = EW'(QUEUE_DEPTH);
      end
      pol = req_ff.policy;
      if (pol == POL_DEFAULT) begin
         pol = default_policy_ff;
      end
      if (pol == POL_DEFAULT) begin
         pol = POL_DROP_NEWEST;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (req_ff.op)
               OP_ENQUEUE: state_in = stop_ff ? ST_RESP : ST_QSCAN;
               OP_POP: begin
                  state_in = ((count_ff == '0) || act_stat.full) ? ST_RESP : ST_POP;
               end
               OP_FINISH: state_in = ST_FINISH;
               default:   state_in = ST_RESP;
            endcase
         end
         ST_QSCAN: begin
            if (scan_done) begin
               state_in = qhit_ff ? ST_RESP : ST_ASCAN;
            end
         end
         ST_ASCAN: begin
            if (act_stat.done) begin
               state_in = (act_stat.hit || reject) ? ST_RESP : ST_APPEND;
            end
         end
         ST_APPEND: state_in = ST_RESP;
         ST_POP:    state_in = ST_RESP;
         ST_FINISH: begin
            if (act_stat.done) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and register updates.
   always_comb begin
      req_in            = req_ff;
      head_in           = head_ff;
      tail_in           = tail_ff;
      count_in          = count_ff;
      stop_in           = stop_ff;
      capacity_in       = capacity_ff;
      default_policy_in = default_policy_ff;
      scan_ptr_in       = scan_ptr_ff;
      scan_rem_in       = scan_rem_ff;
      q_cmp_v_in        = 1'b0;
      qhit_in           = qhit_ff;
      evict_in          = evict_ff;
      status_in         = status_ff;
      kind_in           = kind_ff;
      okey_in           = okey_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_CAPACITY:       capacity_in = csr_wdata;
            CSR_DEFAULT_POLICY: default_policy_in = policy_type'(csr_wdata[1:0]);
            default: ;
         endcase
      end
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in = req;
            end
         end
         ST_EXEC: begin
            status_in   = STAT_DONE;
            kind_in     = KIND_NONE;
            okey_in     = '0;
            scan_ptr_in = head_ff;
            scan_rem_in = count_ff;
            qhit_in     = 1'b0;
            case (req_ff.op)
               OP_ENQUEUE: begin
                  if (stop_ff) begin
                     status_in = STAT_STOPPED;
                  end
               end
               OP_POP: begin
                  if (count_ff == '0) begin
                     status_in = STAT_EMPTY;
                  end else if (act_stat.full) begin
                     status_in = STAT_ACTIVE_FULL;
                  end
               end
               OP_CLEAR: begin
                  count_in = '0;
                  head_in  = '0;
                  tail_in  = '0;
               end
               OP_STOP: stop_in = 1'b1;
               default: ;
            endcase
         end
         ST_QSCAN: begin
            if (scan_rem_ff != '0) begin
               q_cmp_v_in  = 1'b1;
               scan_ptr_in = wrap_inc(scan_ptr_ff);
               scan_rem_in = scan_rem_ff - CW'(1);
            end
            if (q_cmp_v_ff && (q_rdata_ff == key_m)) begin
               qhit_in = 1'b1;
            end
            if (scan_done && qhit_ff) begin
               status_in = STAT_DUPLICATE;
            end
         end
         ST_ASCAN: begin
            if (act_stat.done) begin
               if (act_stat.hit) begin
                  status_in = STAT_DUPLICATE;
               end else if (reject) begin
                  status_in = STAT_FULL_REJECTED;
               end
               evict_in = at_cap && (pol == POL_DROP_OLDEST) && (count_ff != '0);
            end
         end
         ST_APPEND: begin
            tail_in = wrap_inc(tail_ff);
            if (evict_ff) begin
               head_in = wrap_inc(head_ff);
               kind_in = KIND_EVICTED;
               okey_in = KEY_FIELD_W'(q_rdata_ff);
            end else begin
               count_in = count_ff + CW'(1);
            end
         end
         ST_POP: begin
            head_in  = wrap_inc(head_ff);
            count_in = count_ff - CW'(1);
            kind_in  = KIND_POPPED;
            okey_in  = KEY_FIELD_W'(q_rdata_ff);
         end
         default: ;
      endcase
   end

   // Outputs, memory controls and active table commands.
   always_comb begin
      busy              = (state_ff != ST_IDLE);
      csr_ready         = (state_ff == ST_IDLE);
      rsp_valid         = (state_ff == ST_RESP);
      rsp.status        = status_ff;
      rsp.out_kind      = kind_ff;
      rsp.out_key       = okey_ff;
      rsp.queue_count   = QCOUNT_W'(count_ff);
      rsp.active_count  = ACOUNT_W'(act_count);
      rsp.stopped_flag  = stop_ff;
      act_cmd.lookup    = (state_ff == ST_QSCAN) && scan_done && !qhit_ff;
      act_cmd.finish    = (state_ff == ST_EXEC) && (req_ff.op == OP_FINISH);
      act_cmd.insert    = (state_ff == ST_POP);
      act_key           = (state_ff == ST_POP) ? q_rdata_ff : key_m;
      q_raddr           = (state_ff == ST_QSCAN) ? scan_ptr_ff : head_ff;
      q_we              = (state_ff == ST_APPEND);
   end

   always_ff @(posedge clock) begin
      if (q_we) begin
         q_mem[tail_ff] <= key_m;
      end
      q_rdata_ff <= q_mem[q_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         head_ff           <= '0;
         tail_ff           <= '0;
         count_ff          <= '0;
         stop_ff           <= 1'b0;
         capacity_ff       <= CAPACITY_RESET;
         default_policy_ff <= POL_DROP_NEWEST;
         q_cmp_v_ff        <= 1'b0;
      end else begin
         state_ff          <= state_in;
         head_ff           <= head_in;
         tail_ff           <= tail_in;
         count_ff          <= count_in;
         stop_ff           <= stop_in;
         capacity_ff       <= capacity_in;
         default_policy_ff <= default_policy_in;
         q_cmp_v_ff        <= q_cmp_v_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      scan_ptr_ff <= scan_ptr_in;
      scan_rem_ff <= scan_rem_in;
      qhit_ff     <= qhit_in;
      evict_ff    <= evict_in;
      status_ff   <= status_in;
      kind_ff     <= kind_in;
      okey_ff     <= okey_in;
   end

endmodule

// ===== hw/rtl/dbtq_checker.sv =====
// Port-level checks for the deduplicating task queue, bound to the top level.
// Depends on dbtq_pkg and dedup_bounded_task_queue_top_defines.svh.
`include "dedup_bounded_task_queue_top_defines.svh"

module dbtq_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             start,
   input logic                             busy,
   input dbtq_pkg::req_type                req,
   input logic                             rsp_valid,
   input dbtq_pkg::rsp_type                rsp,
   input logic                             csr_valid,
   input logic                             csr_ready,
   input logic [dbtq_pkg::CSR_INDEX_W-1:0] csr_index,
   input logic [dbtq_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import dbtq_pkg::*;

   `DBTQ_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "busy low after accept")
   `DBTQ_ASSERT_SAME(a_rsp_busy, clock, reset, rsp_valid, busy, "result word while not busy")
   `DBTQ_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid, "result word repeated")
   `DBTQ_ASSERT_SAME(a_nokey_zero, clock, reset, rsp_valid && (rsp.out_kind == KIND_NONE), rsp.out_key == '0, "key on result word without key")
   `DBTQ_ASSERT_SAME(a_stop_flag, clock, reset, rsp_valid && (rsp.status == STAT_STOPPED), rsp.stopped_flag, "stopped status without flag")

endmodule

bind dedup_bounded_task_queue_top dbtq_checker u_dbtq_checker (.*);
